>>> rtl/match_frame_axes_unit_assert.svh
// assertion macros for the axis matching block
`ifndef MATCH_FRAME_AXES_UNIT_ASSERT_SVH
`define MATCH_FRAME_AXES_UNIT_ASSERT_SVH

// same-cycle implication
`define MFA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mfa check failed");

// next-cycle implication
`define MFA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mfa check failed");

`endif

>>> rtl/mfa_pkg.sv
package mfa_pkg;

    localparam int NUM_AXES       = 3;
    localparam int COMPONENT_BITS = 16;
    localparam int PROD_W         = 2 * COMPONENT_BITS;
    localparam int ACC_W          = 2 * COMPONENT_BITS + 1;
    localparam int MAG_W          = 2 * COMPONENT_BITS;

    typedef logic [1:0] axis_idx_t;
    typedef logic signed [COMPONENT_BITS-1:0] component_t;

    typedef struct packed {
        axis_idx_t  axis_index;
        component_t first_x;
        component_t first_y;
        component_t first_z;
        component_t second_x;
        component_t second_y;
        component_t second_z;
        logic       final_axis;
    } axis_item_t;

    typedef struct packed {
        axis_idx_t match_for_x;
        axis_idx_t match_for_y;
        axis_idx_t match_for_z;
        logic      flip_for_x;
        logic      flip_for_y;
        logic      flip_for_z;
        logic      degenerate;
    } match_item_t;

    typedef struct packed {
        logic      valid;
        logic      first;
        logic      last;
        axis_idx_t row;
        axis_idx_t col;
        axis_idx_t k;
    } mac_op_t;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] sum;
    } mac_res_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } ctl_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctl_status_t;

endpackage

>>> rtl/match_frame_axes_unit.sv
// match_frame_axes_unit: greedy axis matching of two three-axis frames
//
// axis channel (axis_valid/axis_ready/axis_item): each item stores one axis
// of the first frame and one of the second frame in slot axis_index (slot
// three stores nothing). an item with final_axis set starts the matching.
// match channel (match_valid/match_ready/match_item): one result per final
// item, giving the matched second-frame axis and flip bit for each row.
//
// an item without final_axis is taken while the block is idle and gives no result.
// a final item: the nine dot products go through one shared multiplier and
// accumulator, one product per cycle, then a scan of the nine magnitudes
// finds the second pair; axis_ready returns at the same edge at which the
// result register loads. the frame slots are undefined until written;
// reset clears only control state and the result register's valid flag.
// a stalled receiver holds the result in the output register; further
// non-final items are still taken, and the next final item waits at the
// end of its matching until the register is free.
module match_frame_axes_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 axis_valid,
    output logic                 axis_ready,
    input  mfa_pkg::axis_item_t  axis_item,
    output logic                 match_valid,
    input  logic                 match_ready,
    output mfa_pkg::match_item_t match_item
);
    import mfa_pkg::*;

    `include "match_frame_axes_unit_assert.svh"

    component_t  first_axes_reg  [NUM_AXES][NUM_AXES];
    component_t  second_axes_reg [NUM_AXES][NUM_AXES];
    logic        accept;
    ctl_cmd_t    cmd;
    ctl_status_t status;
    mac_op_t     op;
    mac_res_t    res;
    component_t  op_a, op_b;
    match_item_t result;
    logic        match_valid_reg;
    match_item_t match_item_reg;

    assign accept       = axis_valid && axis_ready;
    assign cmd.start    = accept && axis_item.final_axis;
    assign cmd.out_free = !match_valid_reg || match_ready;
    assign axis_ready   = status.idle;

    always_ff @(posedge clk)
    begin
        if (accept && axis_item.axis_index < axis_idx_t'(NUM_AXES))
        begin
            first_axes_reg[axis_item.axis_index][0]  <= axis_item.first_x;
            first_axes_reg[axis_item.axis_index][1]  <= axis_item.first_y;
            first_axes_reg[axis_item.axis_index][2]  <= axis_item.first_z;
            second_axes_reg[axis_item.axis_index][0] <= axis_item.second_x;
            second_axes_reg[axis_item.axis_index][1] <= axis_item.second_y;
            second_axes_reg[axis_item.axis_index][2] <= axis_item.second_z;
        end
    end

    assign op_a = first_axes_reg[op.row][op.k];
    assign op_b = second_axes_reg[op.col][op.k];

    mfa_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .a     (op_a),
        .b     (op_b),
        .res   (res)
    );

    mfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .res    (res),
        .op     (op),
        .status (status),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_valid_reg <= 1'b0;
        else if (status.done)
            match_valid_reg <= 1'b1;
        else if (match_ready)
            match_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
            match_item_reg <= result;
    end

    assign match_valid = match_valid_reg;
    assign match_item  = match_item_reg;

    `MFA_ASSERT_NEXT(a_final_blocks_input, cmd.start, !axis_ready)
    `MFA_ASSERT_NOW(a_result_after_busy, $rose(match_valid), !$past(axis_ready))
    `MFA_ASSERT_NOW(a_full_match_is_perm,
        match_valid && !match_item.degenerate,
        match_item.match_for_x != match_item.match_for_y
        && match_item.match_for_x != match_item.match_for_z
        && match_item.match_for_y != match_item.match_for_z)

endmodule

>>> rtl/mfa_mac.sv
module mfa_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  mfa_pkg::mac_op_t   op,
    input  mfa_pkg::component_t a,
    input  mfa_pkg::component_t b,
    output mfa_pkg::mac_res_t  res
);
    import mfa_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_valid_reg;
    logic                     p_first_reg;
    logic                     p_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic                     done_reg;

    always_comb
    begin
        if (p_first_reg)
            acc_base = '0;
        else
            acc_base = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= op.valid;
            p_first_reg <= op.first;
            p_last_reg  <= op.last;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
        if (p_valid_reg)
            acc_reg <= acc_base + ACC_W'(prod_reg);
    end

    assign res.valid = done_reg;
    assign res.sum   = acc_reg;

endmodule

>>> rtl/mfa_ctrl.sv
module mfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfa_pkg::ctl_cmd_t    cmd,
    input  mfa_pkg::mac_res_t    res,
    output mfa_pkg::mac_op_t     op,
    output mfa_pkg::ctl_status_t status,
    output mfa_pkg::match_item_t result
);
    import mfa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DOT, S_DRAIN, S_SCAN, S_DONE} state_t;

    localparam axis_idx_t LAST_IDX = axis_idx_t'(NUM_AXES - 1);

    state_t             state_reg;
    axis_idx_t          iss_row_reg, iss_col_reg, iss_k_reg;
    axis_idx_t          res_row_reg, res_col_reg;
    axis_idx_t          scan_row_reg, scan_col_reg;
    logic [MAG_W-1:0]   best_reg, best2_reg;
    axis_idx_t          im_reg, jm_reg, is_reg, js_reg;
    logic [MAG_W-1:0]   mag_reg [NUM_AXES][NUM_AXES];
    logic               pos_reg [NUM_AXES][NUM_AXES];

    logic signed [ACC_W-1:0] res_abs;
    logic [MAG_W-1:0]        res_mag;
    logic                    res_pos;
    logic [MAG_W-1:0]        scan_mag;
    logic                    scan_hit;
    axis_idx_t               it, jt;
    axis_idx_t               match [NUM_AXES];
    logic                    written [NUM_AXES];
    logic                    flip [NUM_AXES];

    function automatic axis_idx_t leftover(input axis_idx_t a, input axis_idx_t b);
        axis_idx_t r;
        r = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (axis_idx_t'(i) != a && axis_idx_t'(i) != b)
                r = axis_idx_t'(i);
        end
        return r;
    endfunction

    always_comb
    begin
        res_abs  = res.sum[ACC_W-1] ? -res.sum : res.sum;
        res_mag  = res_abs[MAG_W-1:0];
        res_pos  = !res.sum[ACC_W-1] && (res.sum != '0);
        scan_mag = mag_reg[scan_row_reg][scan_col_reg];
        scan_hit = (scan_row_reg != im_reg) && (scan_col_reg != jm_reg)
                   && (scan_mag > best2_reg);
    end

    // third pair and final assembly, later pairs overwrite earlier ones
    always_comb
    begin
        it = leftover(im_reg, is_reg);
        jt = leftover(jm_reg, js_reg);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            match[i]   = '0;
            written[i] = 1'b0;
        end
        match[im_reg]   = jm_reg;
        written[im_reg] = 1'b1;
        match[is_reg]   = js_reg;
        written[is_reg] = 1'b1;
        match[it]       = jt;
        written[it]     = 1'b1;
        for (int i = 0; i < NUM_AXES; i++)
            flip[i] = written[i] && !pos_reg[i][match[i]];
        result.match_for_x = match[0];
        result.match_for_y = match[1];
        result.match_for_z = match[2];
        result.flip_for_x  = flip[0];
        result.flip_for_y  = flip[1];
        result.flip_for_z  = flip[2];
        result.degenerate  = (best_reg == '0) || (best2_reg == '0);
    end

    assign op.valid = (state_reg == S_DOT);
    assign op.first = (iss_k_reg == '0);
    assign op.last  = (iss_k_reg == LAST_IDX);
    assign op.row   = iss_row_reg;
    assign op.col   = iss_col_reg;
    assign op.k     = iss_k_reg;

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_DONE) && cmd.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            iss_row_reg  <= '0;
            iss_col_reg  <= '0;
            iss_k_reg    <= '0;
            res_row_reg  <= '0;
            res_col_reg  <= '0;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            best_reg     <= '0;
            best2_reg    <= '0;
            im_reg       <= '0;
            jm_reg       <= '0;
            is_reg       <= '0;
            js_reg       <= '0;
        end
        else
        begin
            // first greedy pass runs as each dot product lands
            if (res.valid)
            begin
                if (res_mag > best_reg)
                begin
                    best_reg <= res_mag;
                    im_reg   <= res_row_reg;
                    jm_reg   <= res_col_reg;
                end
                if (res_col_reg == LAST_IDX)
                begin
                    res_col_reg <= '0;
                    res_row_reg <= res_row_reg + 2'd1;
                end
                else
                    res_col_reg <= res_col_reg + 2'd1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        state_reg    <= S_DOT;
                        iss_row_reg  <= '0;
                        iss_col_reg  <= '0;
                        iss_k_reg    <= '0;
                        res_row_reg  <= '0;
                        res_col_reg  <= '0;
                        scan_row_reg <= '0;
                        scan_col_reg <= '0;
                        best_reg     <= '0;
                        best2_reg    <= '0;
                        im_reg       <= '0;
                        jm_reg       <= '0;
                        is_reg       <= '0;
                        js_reg       <= '0;
                    end
                end
                S_DOT:
                begin
                    if (iss_k_reg == LAST_IDX)
                    begin
                        iss_k_reg <= '0;
                        if (iss_col_reg == LAST_IDX)
                        begin
                            iss_col_reg <= '0;
                            if (iss_row_reg == LAST_IDX)
                                state_reg <= S_DRAIN;
                            else
                                iss_row_reg <= iss_row_reg + 2'd1;
                        end
                        else
                            iss_col_reg <= iss_col_reg + 2'd1;
                    end
                    else
                        iss_k_reg <= iss_k_reg + 2'd1;
                end
                S_DRAIN:
                begin
                    if (res.valid && res_row_reg == LAST_IDX && res_col_reg == LAST_IDX)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        best2_reg <= scan_mag;
                        is_reg    <= scan_row_reg;
                        js_reg    <= scan_col_reg;
                    end
                    if (scan_col_reg == LAST_IDX)
                    begin
                        scan_col_reg <= '0;
                        if (scan_row_reg == LAST_IDX)
                            state_reg <= S_DONE;
                        else
                            scan_row_reg <= scan_row_reg + 2'd1;
                    end
                    else
                        scan_col_reg <= scan_col_reg + 2'd1;
                end
                S_DONE:
                begin
                    if (cmd.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            mag_reg[res_row_reg][res_col_reg] <= res_mag;
            pos_reg[res_row_reg][res_col_reg] <= res_pos;
        end
    end

endmodule

>>> sim/match_frame_axes_unit_chk.sv
module match_frame_axes_unit_chk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 axis_valid,
    input  logic                 axis_ready,
    input  mfa_pkg::axis_item_t  axis_item,
    input  logic                 match_valid,
    input  logic                 match_ready,
    input  mfa_pkg::match_item_t match_item,
    output int                   fail_count,
    output int                   pending,
    output int                   matches_seen,
    output int                   degenerate_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mfa_pkg::*;

    component_t  first_axes  [NUM_AXES][3];
    component_t  second_axes [NUM_AXES][3];
    match_item_t expected_matches [$];
    int          fail_total  = 0;
    int          match_total = 0;
    int          degen_total = 0;

    // greedy matching on exact dot-product magnitudes
    function automatic match_item_t match_axes();
        longint      dot;
        longint      mag [3][3];
        bit          positive [3][3];
        longint      top1;
        longint      top2;
        int          pick [3];
        bit          row_used [3];
        int          r1;
        int          c1;
        int          r2;
        int          c2;
        int          r3;
        int          c3;
        match_item_t res;
        top1 = 0;
        r1 = 0;
        c1 = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dot = 0;
                for (int k = 0; k < 3; k++)
                    dot += longint'(first_axes[r][k]) * longint'(second_axes[c][k]);
                mag[r][c]      = (dot < 0) ? -dot : dot;
                positive[r][c] = dot > 0;
                if (mag[r][c] > top1)
                begin
                    top1 = mag[r][c];
                    r1 = r;
                    c1 = c;
                end
            end
        end
        top2 = 0;
        r2 = 0;
        c2 = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (r != r1 && c != c1 && mag[r][c] > top2)
                begin
                    top2 = mag[r][c];
                    r2 = r;
                    c2 = c;
                end
        // leftover row and column: highest one outside the first two pairs
        r3 = 0;
        c3 = 0;
        for (int r = 0; r < 3; r++)
            if (r != r1 && r != r2)
                r3 = r;
        for (int c = 0; c < 3; c++)
            if (c != c1 && c != c2)
                c3 = c;
        pick     = '{0, 0, 0};
        row_used = '{0, 0, 0};
        pick[r1] = c1;
        row_used[r1] = 1'b1;
        pick[r2] = c2;
        row_used[r2] = 1'b1;
        pick[r3] = c3;
        row_used[r3] = 1'b1;
        res.match_for_x = axis_idx_t'(pick[0]);
        res.match_for_y = axis_idx_t'(pick[1]);
        res.match_for_z = axis_idx_t'(pick[2]);
        res.flip_for_x  = row_used[0] && !positive[0][pick[0]];
        res.flip_for_y  = row_used[1] && !positive[1][pick[1]];
        res.flip_for_z  = row_used[2] && !positive[2][pick[2]];
        res.degenerate  = (top1 == 0) || (top2 == 0);
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_total++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        match_item_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_AXES; r++)
            begin
                first_axes[r]  = '{default: '0};
                second_axes[r] = '{default: '0};
            end
            expected_matches.delete();
        end
        else
        begin
            if (match_valid && match_ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    fail_total++;
                    $display("%0t unexpected match item: expected none, got %h",
                             $time, match_item);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    check_field("match_for_x", want.match_for_x, match_item.match_for_x);
                    check_field("match_for_y", want.match_for_y, match_item.match_for_y);
                    check_field("match_for_z", want.match_for_z, match_item.match_for_z);
                    check_field("flip_for_x", want.flip_for_x, match_item.flip_for_x);
                    check_field("flip_for_y", want.flip_for_y, match_item.flip_for_y);
                    check_field("flip_for_z", want.flip_for_z, match_item.flip_for_z);
                    check_field("degenerate", want.degenerate, match_item.degenerate);
                    match_total++;
                    if (want.degenerate)
                        degen_total++;
                end
            end
            if (axis_valid && axis_ready)
            begin
                // slot three stores nothing
                if (axis_item.axis_index < NUM_AXES)
                begin
                    first_axes[axis_item.axis_index] =
                        '{axis_item.first_x, axis_item.first_y, axis_item.first_z};
                    second_axes[axis_item.axis_index] =
                        '{axis_item.second_x, axis_item.second_y, axis_item.second_z};
                end
                if (axis_item.final_axis)
                    expected_matches.insert(expected_matches.size(), match_axes());
            end
        end
        fail_count      <= fail_total;
        pending         <= expected_matches.size();
        matches_seen    <= match_total;
        degenerate_seen <= degen_total;
    end

endmodule

>>> sim/match_frame_axes_unit_tb.sv
module match_frame_axes_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfa_pkg::*;

    localparam int         ITEM_TARGET = 800;
    localparam int         WATCH_LIMIT = 4000;
    localparam int         TAIL_CYCLES = 60;
    localparam component_t UNIT        = 16'sd16384;
    localparam component_t POS_MAX     = 16'sd32767;
    localparam component_t NEG_MAX     = component_t'(16'h8000);

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        axis_valid  = 1'b0;
    logic        axis_ready;
    axis_item_t  axis_item   = '0;
    logic        match_valid;
    logic        match_ready = 1'b0;
    match_item_t match_item;

    int fail_count;
    int pending;
    int matches_seen;
    int degenerate_seen;

    bit         steady     = 1'b0;
    int         rx_hold    = 0;
    int         idle_run   = 0;
    int         items_sent = 0;
    component_t first_set  [3][3];
    component_t second_set [3][3];

    always #5 clk = ~clk;

    match_frame_axes_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .axis_valid  (axis_valid),
        .axis_ready  (axis_ready),
        .axis_item   (axis_item),
        .match_valid (match_valid),
        .match_ready (match_ready),
        .match_item  (match_item)
    );

    match_frame_axes_unit_chk u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .axis_valid      (axis_valid),
        .axis_ready      (axis_ready),
        .axis_item       (axis_item),
        .match_valid     (match_valid),
        .match_ready     (match_ready),
        .match_item      (match_item),
        .fail_count      (fail_count),
        .pending         (pending),
        .matches_seen    (matches_seen),
        .degenerate_seen (degenerate_seen)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic component_t extreme_value();
        case ($urandom_range(0, 4))
            0:       return NEG_MAX;
            1:       return POS_MAX;
            2:       return '0;
            3:       return UNIT;
            default: return -UNIT;
        endcase
    endfunction

    always @(posedge clk)
    begin : receiver
        int n;
        if (!rst_n)
            n = 0;
        else if (match_valid && match_ready)
            n = idle_len();
        else if (rx_hold > 0)
            n = rx_hold - 1;
        else if ($urandom_range(0, 15) == 0)
            n = idle_len();
        else
            n = 0;
        rx_hold     <= n;
        match_ready <= rst_n && (n == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((axis_valid && axis_ready) || (match_valid && match_ready))
                idle_run <= 0;
            else if (idle_run >= WATCH_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_run <= idle_run + 1;
        end
    end

    task automatic send_axis(input int slot, input component_t fx, input component_t fy,
                             input component_t fz, input component_t sx,
                             input component_t sy, input component_t sz, input bit fin);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            axis_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        axis_valid <= 1'b1;
        axis_item  <= '{axis_index: axis_idx_t'(slot), first_x: fx, first_y: fy,
                        first_z: fz, second_x: sx, second_y: sy, second_z: sz,
                        final_axis: fin};
        do
            @(posedge clk);
        while (!axis_ready);
        items_sent++;
    endtask

    // hold the sender off until every result is back
    task automatic drain();
        axis_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_perm(output int p [3]);
        int j;
        int t;
        p = '{0, 1, 2};
        j = $urandom_range(0, 2);
        t = p[2];
        p[2] = p[j];
        p[j] = t;
        j = $urandom_range(0, 1);
        t = p[1];
        p[1] = p[j];
        p[j] = t;
    endtask

    task automatic fill_set();
        int mode;
        int pa [3];
        int pb [3];
        mode = $urandom_range(0, 9);
        random_perm(pa);
        random_perm(pb);
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (mode < 4)
                begin
                    first_set[i][k]  = component_t'($urandom);
                    second_set[i][k] = component_t'($urandom);
                end
                else if (mode < 8)
                begin
                    // near-orthonormal frames, second a signed permutation of the first
                    first_set[i][k] = (k == pa[i])
                        ? ($urandom_range(0, 1) ? UNIT : -UNIT)
                        : component_t'(int'($urandom_range(0, 600)) - 300);
                    second_set[i][k] = (k == pb[i])
                        ? ($urandom_range(0, 1) ? UNIT : -UNIT)
                        : component_t'(int'($urandom_range(0, 600)) - 300);
                end
                else if (mode == 8)
                begin
                    first_set[i][k]  = component_t'(int'($urandom_range(0, 4)) - 2);
                    second_set[i][k] = component_t'(int'($urandom_range(0, 4)) - 2);
                end
                else
                begin
                    first_set[i][k]  = extreme_value();
                    second_set[i][k] = extreme_value();
                end
            end
        end
    endtask

    // send count rows of the current set in random slot order, final on the last
    task automatic send_set(input int count);
        int order [3];
        int s;
        random_perm(order);
        for (int n = 0; n < count; n++)
        begin
            s = order[n];
            send_axis(s, first_set[s][0], first_set[s][1], first_set[s][2],
                      second_set[s][0], second_set[s][1], second_set[s][2],
                      n == count - 1);
        end
    endtask

    initial
    begin : stimulus
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // identity frames
        send_axis(0, UNIT, 0, 0, UNIT, 0, 0, 1'b0);
        send_axis(1, 0, UNIT, 0, 0, UNIT, 0, 1'b0);
        send_axis(2, 0, 0, UNIT, 0, 0, UNIT, 1'b1);
        // permuted second frame with flips
        send_axis(0, UNIT, 0, 0, 0, -UNIT, 0, 1'b0);
        send_axis(1, 0, UNIT, 0, 0, 0, UNIT, 1'b0);
        send_axis(2, 0, 0, UNIT, -UNIT, 0, 0, 1'b1);
        // component extremes
        send_axis(0, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 1'b0);
        send_axis(1, POS_MAX, POS_MAX, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, 1'b0);
        send_axis(2, POS_MAX, NEG_MAX, 1, POS_MAX, POS_MAX, POS_MAX, 1'b1);
        // all-zero frames
        send_axis(0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_axis(1, 0, 0, 0, 0, 0, 0, 1'b0);
        send_axis(2, 0, 0, 0, 0, 0, 0, 1'b1);
        // a single non-zero pair, second maximum stays zero
        send_axis(1, 0, 0, 5, 0, 0, -7, 1'b1);
        // all nine products tied
        send_axis(0, 100, 0, 0, 100, 0, 0, 1'b0);
        send_axis(1, 100, 0, 0, 100, 0, 0, 1'b0);
        send_axis(2, 100, 0, 0, 100, 0, 0, 1'b1);
        // slot three stores nothing but still runs the matching
        send_axis(NUM_AXES, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, 1'b0);
        send_axis(NUM_AXES, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX, 1'b1);
        // exact cancellation on one pair
        send_axis(0, UNIT, UNIT, 0, UNIT, -UNIT, 0, 1'b1);
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            r = $urandom_range(0, 99);
            fill_set();
            if (r < 80)
                send_set(3);
            else if (r < 90)
                send_set($urandom_range(1, 2));
            else
                send_axis($urandom_range(0, NUM_AXES), first_set[0][0], first_set[0][1],
                          first_set[0][2], second_set[0][0], second_set[0][1],
                          second_set[0][2], $urandom_range(0, 1));
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d axis items; %0d matchings checked, %0d of them degenerate",
                 items_sent, matches_seen, degenerate_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
